[hdl/tcsb_pkg.sv]
// package for the text console scroll buffer
// screen geometry, beat types, op codes and the hex digit helper; no dependencies
package tcsb_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int CUR_W   = $clog2(CELLS + 1);
  localparam int ADDR_W  = $clog2(CELLS);

  // op codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_HEX   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // register byte addresses
  localparam logic [1:0] REG_ATTR_ADDR = 2'd0;
  localparam logic [7:0] ATTR_RESET    = 8'h07;

  // characters
  localparam logic [7:0] BLANK     = 8'h20;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_X    = 8'h78;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  char_code;
    logic [31:0] hex_value;
    logic [10:0] cell_index;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic [10:0] cursor_position;
  } out_beat_t;

  // screen memory request from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // read result handed to the output register
  typedef struct packed {
    logic             valid;
    logic [7:0]       cell_char;
    logic [CUR_W-1:0] cursor;
  } res_t;

  // upper-case ascii hex digit
  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    logic [7:0] n;
    n = {4'd0, nib};
    hex_ascii = (nib < 4'd10) ? (n + 8'd48) : (n + 8'd55);
  endfunction

endpackage

[hdl/tcsb_ram.sv]
// single write port, single read port screen memory with registered read data
// generic; no package dependency
module tcsb_ram #(
  parameter int DEPTH  = 2000,
  parameter int DATA_W = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/tcsb_seq.sv]
// sequencer: cursor, clear and scroll sweeps, character puts and cell reads
// drives the screen memory; clear and scroll sweeps share one address counter; uses tcsb_pkg
module tcsb_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  tcsb_pkg::in_beat_t in_data,
  output logic               in_stall,
  input  logic               out_free,
  input  logic [7:0]         rdata,
  output tcsb_pkg::mem_req_t mem,
  output tcsb_pkg::res_t     res
);
  import tcsb_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_PUT    = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_RDATA  = 3'd5;

  localparam logic [CUR_W-1:0] CUR_FULL = CUR_W'(CELLS);
  localparam logic [CUR_W-1:0] CUR_LAST = CUR_W'(CELLS - COLUMNS);
  localparam logic [CUR_W-1:0] CNT_END  = CUR_W'(CELLS - 1);

  logic [2:0]       state;
  logic [CUR_W-1:0] cnt;
  logic [CUR_W-1:0] cursor;
  logic             hex_mode;
  logic [3:0]       k;
  logic [31:0]      word;
  logic [7:0]       ch;
  logic [10:0]      idx;
  logic [7:0]       put_char;
  logic [CUR_W-1:0] cnt_dec;
  logic [CUR_W-1:0] cnt_inc;

  assign in_stall = (state != S_IDLE);
  assign cnt_dec  = cnt - 1'b1;
  assign cnt_inc  = cnt + CUR_W'(COLUMNS);

  // character for the current put
  always_comb begin
    if (!hex_mode) begin
      put_char = ch;
    end else if (k == 4'd0) begin
      put_char = CHAR_ZERO;
    end else if (k == 4'd1) begin
      put_char = CHAR_X;
    end else begin
      put_char = hex_ascii(word[31:28]);
    end
  end

  // memory requests
  always_comb begin
    mem = '0;
    case (state)
      S_CLEAR: begin
        mem.we    = 1'b1;
        mem.waddr = cnt[ADDR_W-1:0];
        mem.wdata = BLANK;
      end
      S_PUT: begin
        if (cursor != CUR_FULL) begin
          mem.we    = 1'b1;
          mem.waddr = cursor[ADDR_W-1:0];
          mem.wdata = put_char;
        end
      end
      S_SCROLL: begin
        // read one row ahead, write the previous cycle's data one cell back
        if (cnt < CUR_LAST) begin
          mem.re    = 1'b1;
          mem.raddr = cnt_inc[ADDR_W-1:0];
        end
        if (cnt != '0) begin
          mem.we    = 1'b1;
          mem.waddr = cnt_dec[ADDR_W-1:0];
          mem.wdata = (cnt <= CUR_LAST) ? rdata : BLANK;
        end
      end
      S_READ: begin
        mem.re    = 1'b1;
        mem.raddr = idx[ADDR_W-1:0];
      end
      default: begin
        mem = '0;
      end
    endcase
  end

  // read result
  always_comb begin
    res.valid     = (state == S_RDATA) && out_free;
    res.cell_char = (idx < 11'(CELLS)) ? rdata : 8'd0;
    res.cursor    = cursor;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      cnt    <= '0;
      cursor <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_END) begin
            cursor <= '0;
            state  <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            ch       <= in_data.char_code;
            word     <= in_data.hex_value;
            idx      <= in_data.cell_index;
            k        <= 4'd0;
            hex_mode <= (in_data.op == OP_HEX);
            case (in_data.op)
              OP_WRITE: state <= S_PUT;
              OP_HEX:   state <= S_PUT;
              OP_CLEAR: begin
                cnt   <= '0;
                state <= S_CLEAR;
              end
              OP_READ:  state <= S_READ;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_PUT: begin
          if (cursor == CUR_FULL) begin
            cnt   <= '0;
            state <= S_SCROLL;
          end else begin
            cursor <= cursor + 1'b1;
            if (hex_mode && (k != 4'd9)) begin
              k <= k + 1'b1;
              if (k >= 4'd2) begin
                word <= {word[27:0], 4'd0};
              end
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SCROLL: begin
          cnt <= cnt + 1'b1;
          if (cnt == CUR_FULL) begin
            cursor <= CUR_LAST;
            state  <= S_PUT;
          end
        end
        S_READ: begin
          state <= S_RDATA;
        end
        S_RDATA: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // cursor stays within the screen plus the full mark
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= CUR_FULL)
    else $error("cursor beyond full mark");

  // idle never touches the store
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!mem.we && !mem.re))
    else $error("memory access while idle");

  // a scroll never writes the cell it reads in the same cycle
  a_scroll_hazard: assert property (@(posedge clk) disable iff (rst)
    (mem.we && mem.re) |-> (mem.waddr != mem.raddr))
    else $error("read and write collide");

  // scroll ends with the cursor at the start of the last row
  a_scroll_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCROLL && cnt == CUR_FULL) |=> (cursor == CUR_LAST && state == S_PUT))
    else $error("scroll left cursor misplaced");

  // clear ends idle with the cursor home
  a_clear_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && cnt == CNT_END) |=> (cursor == '0 && state == S_IDLE))
    else $error("clear left cursor misplaced");

endmodule

[hdl/text_console_scroll_buffer.sv]
// Text console scroll buffer, 80x25 character cells with a write cursor. After reset the
// block blanks the store to spaces and holds in_stall high meanwhile; configuration writes
// are taken at any time. Every item goes through one sequencer with one memory read port and
// one write port, and the next item is taken only once the last is done: a hex word puts ten
// characters, and a read waits for room in the output register. A write at a full screen first
// scrolls, which walks the store once, one cell per cycle. Reads return the cell character, the
// current attribute register and cursor; the output register lets a read result wait
// while the next item is accepted.
// top level: apb attribute register, output register; uses tcsb_pkg, tcsb_seq, tcsb_ram
module text_console_scroll_buffer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcsb_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tcsb_pkg::out_beat_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import tcsb_pkg::*;

  logic [7:0] attr;
  logic       out_free;
  logic [7:0] rdata;
  mem_req_t   mem;
  res_t       res;

  // attribute register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_ATTR_ADDR) ? {24'd0, attr} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == REG_ATTR_ADDR)) begin
      attr <= pwdata[7:0];
    end
  end

  // output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data.cell_char       <= res.cell_char;
      out_data.cell_attr       <= attr;
      out_data.cursor_position <= 11'(res.cursor);
    end
  end

  tcsb_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_free (out_free),
    .rdata    (rdata),
    .mem      (mem),
    .res      (res)
  );

  tcsb_ram #(
    .DEPTH  (CELLS),
    .DATA_W (8)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

endmodule

[tb/tb_text_console_scroll_buffer.sv]
// self-checking testbench for the text console scroll buffer
// keeps its own copy of the screen, cursor and attribute and checks every read beat
// depends on tcsb_pkg and text_console_scroll_buffer
`timescale 1ns / 1ps

module tb_text_console_scroll_buffer;
  import tcsb_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned SETTLE_CYCLES = 4200;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned PHASE_BEATS   = 610;
  localparam logic [7:0]  HEX_TEN       = 8'h41;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_beat_t in_data;
  logic out_valid;
  logic out_stall;
  out_beat_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // beats waiting for the driver and read results waiting for the block
  in_beat_t pending_beats[$];
  out_beat_t expected_cells[$];

  // screen copy kept alongside the block
  logic [7:0] screen_model [CELLS];
  int unsigned model_cursor;
  logic [7:0] model_attr;

  logic in_took;
  logic hold_start;
  int unsigned hold_left;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned beats_taken;
  int unsigned reads_checked;
  int unsigned clears_seen;
  int unsigned scrolls_seen;

  text_console_scroll_buffer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected 0x%0h, got 0x%0h (cycle %0d)",
               what, want, got, cycle_count);
    end
  endtask

  // store one character at the cursor, scrolling first when the screen is full
  task automatic put_model_char(input logic [7:0] ch);
    if (model_cursor >= CELLS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = BLANK;
      model_cursor = CELLS - COLUMNS;
      scrolls_seen++;
    end
    screen_model[model_cursor] = ch;
    model_cursor++;
  endtask

  // advance the screen copy by one accepted beat, queue the read result if any
  task automatic predict_screen(input in_beat_t b);
    logic [3:0] nib;
    out_beat_t res;
    case (b.op)
      OP_WRITE: put_model_char(b.char_code);
      OP_HEX: begin
        put_model_char(CHAR_ZERO);
        put_model_char(CHAR_X);
        for (int k = 7; k >= 0; k--) begin
          nib = b.hex_value[k*4 +: 4];
          put_model_char(nib < 4'd10 ? CHAR_ZERO + {4'd0, nib}
                                     : HEX_TEN + {4'd0, nib} - 8'd10);
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK;
        model_cursor = 0;
        clears_seen++;
      end
      default: begin
        res.cell_char = (b.cell_index < CELLS) ? screen_model[b.cell_index] : 8'd0;
        res.cell_attr = model_attr;
        res.cursor_position = model_cursor[10:0];
        expected_cells.push_back(res);
      end
    endcase
  endtask

  // input driver: new beat only after the last one was taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data <= pending_beats.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long output hold-off counter
  always @(negedge clk) begin
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output stall, random or held off
  always @(negedge clk) begin
    out_stall <= !rst && (hold_start || hold_left > 1 ||
                          $urandom_range(0, 99) < recv_idle_pct);
  end

  // monitor: check result beats, then predict from accepted input beats
  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_cells.size() == 0) begin
          note_mismatch("unexpected result beat", 32'd0, {5'd0, out_data});
        end else begin
          want = expected_cells.pop_front();
          reads_checked++;
          if (out_data.cell_char !== want.cell_char)
            note_mismatch("cell_char", 32'(want.cell_char), 32'(out_data.cell_char));
          if (out_data.cell_attr !== want.cell_attr)
            note_mismatch("cell_attr", 32'(want.cell_attr), 32'(out_data.cell_attr));
          if (out_data.cursor_position !== want.cursor_position)
            note_mismatch("cursor_position", 32'(want.cursor_position),
                          32'(out_data.cursor_position));
        end
      end
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        beats_taken++;
        predict_screen(in_data);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic queue_beat(input logic [1:0] op, input logic [7:0] ch,
                            input logic [31:0] word, input logic [10:0] idx);
    in_beat_t b;
    b.op = op;
    b.char_code = ch;
    b.hex_value = word;
    b.cell_index = idx;
    pending_beats.push_back(b);
  endtask

  // random beat: mostly writes and reads, clears rare so the screen fills and scrolls
  task automatic queue_random_beat();
    int unsigned pick;
    logic [1:0] op;
    logic [31:0] word;
    logic [10:0] idx;
    pick = $urandom_range(0, 999);
    if (pick < 3) op = OP_CLEAR;
    else if (pick < 320) op = OP_WRITE;
    else if (pick < 700) op = OP_HEX;
    else op = OP_READ;
    case ($urandom_range(0, 15))
      0: word = 32'h0000_0000;
      1: word = 32'hFFFF_FFFF;
      default: word = $urandom();
    endcase
    if ($urandom_range(0, 9) == 0) idx = 11'($urandom_range(CELLS, 2047));
    else idx = 11'($urandom_range(0, CELLS - 1));
    queue_beat(op, 8'($urandom_range(0, 255)), word, idx);
  endtask

  // wait until every beat is in and every read is back, then let a scroll or clear finish
  task automatic drain_and_settle();
    while (pending_beats.size() != 0 || in_valid || expected_cells.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write of the attribute register followed by a read back
  task automatic write_attr(input logic [7:0] v);
    logic [31:0] got;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = REG_ATTR_ADDR;
    pwdata = ($urandom() & 32'hFFFF_FF00) | {24'd0, v};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    model_attr = v;
    if (got[7:0] !== v) note_mismatch("attribute read back", 32'(v), 32'(got[7:0]));
  endtask

  task automatic run_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                  input logic hold_off);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < PHASE_BEATS; n++) queue_random_beat();
    if (hold_off) begin
      @(posedge clk);
      hold_start <= 1'b1;
      @(posedge clk);
      hold_start <= 1'b0;
    end
    drain_and_settle();
  endtask

  // stimulus and end of run
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_took = 1'b0;
    hold_start = 1'b0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cycle_count = 0;
    mismatches = 0;
    beats_taken = 0;
    reads_checked = 0;
    clears_seen = 0;
    scrolls_seen = 0;
    for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK;
    model_cursor = 0;
    model_attr = ATTR_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: blank screen after reset, range edges, writes, hex words, clear
    queue_beat(OP_READ, 8'h00, 32'h0, 11'd0);
    queue_beat(OP_READ, 8'hFF, 32'hFFFF_FFFF, 11'd1999);
    queue_beat(OP_READ, 8'h00, 32'h0, 11'd2000);
    queue_beat(OP_READ, 8'hFF, 32'hFFFF_FFFF, 11'd2047);
    queue_beat(OP_WRITE, 8'h00, 32'hFFFF_FFFF, 11'd2047);
    queue_beat(OP_WRITE, 8'hFF, 32'h0, 11'd0);
    queue_beat(OP_WRITE, 8'h41, 32'h1234_5678, 11'd5);
    queue_beat(OP_HEX, 8'hFF, 32'h0000_0000, 11'd2047);
    queue_beat(OP_HEX, 8'h00, 32'hFFFF_FFFF, 11'd0);
    queue_beat(OP_HEX, 8'h5A, 32'h0123_4567, 11'd3);
    queue_beat(OP_HEX, 8'hA5, 32'h89AB_CDEF, 11'd3);
    for (int i = 0; i < 5; i++) queue_beat(OP_READ, 8'h00, 32'h0, 11'(i));
    queue_beat(OP_READ, 8'h00, 32'h0, 11'd12);
    queue_beat(OP_READ, 8'h00, 32'h0, 11'd32);
    queue_beat(OP_READ, 8'h00, 32'h0, 11'd42);
    queue_beat(OP_READ, 8'h00, 32'h0, 11'd43);
    queue_beat(OP_CLEAR, 8'hFF, 32'hFFFF_FFFF, 11'd2047);
    queue_beat(OP_READ, 8'h00, 32'h0, 11'd0);
    queue_beat(OP_READ, 8'h00, 32'h0, 11'd12);
    drain_and_settle();

    // random phases under different attributes and idling profiles
    write_attr(8'hFF);
    run_random_phase(8, 62, 1'b0);
    write_attr(8'h00);
    run_random_phase(62, 8, 1'b0);
    write_attr(8'($urandom_range(1, 254)));
    run_random_phase(0, 0, 1'b1);

    if (expected_cells.size() != 0) note_mismatch("reads never returned", 32'd0,
                                                  32'(expected_cells.size()));
    $display("%0d input beats, %0d read results checked, %0d clears, %0d scroll steps",
             beats_taken, reads_checked, clears_seen, scrolls_seen);
    $display("attribute at reset, 0xff, 0x00 and a random value; three idling profiles");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
